>>> hw/rtl/wcms_pkg.sv
// Shared constants, register indexes and control types for the window cover motor sequencer.
`timescale 1ns / 1ps
`default_nettype none
package wcms_pkg;

  // History store depth default
  localparam int HISTORY_DEPTH_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SMART_OFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_PCT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DIST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAIN_LVL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT  = 3'd6;

  // Register reset values
  localparam logic        RST_SMART_OFF  = 1'b0;
  localparam logic [6:0]  RST_OPEN_PCT   = 7'd100;
  localparam logic [6:0]  RST_CLOSE_DIST = 7'd5;
  localparam logic [7:0]  RST_OPEN_DIST  = 8'd30;
  localparam logic [7:0]  RST_OPEN_MARG  = 8'd2;
  localparam logic [11:0] RST_RAIN_LVL   = 12'd2048;
  localparam logic [15:0] RST_VAR_LIMIT  = 16'd25;

  // Sensor thresholds
  localparam logic [11:0]        JOY_OPEN_BELOW   = 12'd3000;
  localparam logic [11:0]        JOY_CLOSE_FROM   = 12'd3700;
  localparam logic [9:0]         DIST_VALID_BELOW = 10'd80;
  localparam logic signed [15:0] TILT_POS         = 16'sd160;
  localparam logic signed [15:0] TILT_NEG         = -16'sd160;

  // floor(x/100) for x < 2^15: x*1310 >> 17 is low by at most one
  localparam logic [10:0] RECIP_100   = 11'd1310;
  localparam int          RECIP_SHIFT = 17;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture input word
    logic rd;     // read history slot at head
    logic upd;    // targets, history, running sums
    logic mul;    // first products
    logic mul2;   // threshold product, difference, quotient
    logic fix;    // quotient correction, variance compare
    logic fin;    // motor step, load result word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/window_cover_motor_sequencer_unit.sv
// Top level of the window cover motor sequencer: controller plus datapath.
//
//   Port group | Handshake            | Word
//   in_        | in_valid / in_ready  | joystick, rain, motion, distances, tilt
//   out_       | out_valid / out_ready| motor run/direction, buzzer, goals, settled flags
//   cfg_       | cfg_valid / cfg_ready| cfg_index, cfg_data (register write)
//
// An input word goes through the accept cycle, then six controller steps
// (history read, update, two multiply stages, correction, motor step) before the
// next word is taken; the history RAM read and registered multiply stages set these steps.
// A finished word waits in the output register; the next input word is taken
// while it waits, and the motor step stalls only if the previous word is still there.
// rst_n is synchronous; the history RAM needs no clearing, cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module window_cover_motor_sequencer_unit #(
  parameter int HISTORY_DEPTH = wcms_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wcms_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [11:0]                     in_joystick,
  input  wire logic [11:0]                     in_rain,
  input  wire logic                            in_motion,
  input  wire logic [9:0]                      in_window_distance,
  input  wire logic [9:0]                      in_cover_distance,
  input  wire logic signed [15:0]              in_tilt_x,
  input  wire logic signed [15:0]              in_tilt_y,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_cover_run,
  output logic                                 out_cover_opening,
  output logic                                 out_window_run,
  output logic                                 out_window_closing,
  output logic                                 out_buzzer,
  output logic                                 out_window_goal,
  output logic                                 out_cover_goal,
  output logic                                 out_window_settled,
  output logic                                 out_cover_settled
);
  import wcms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wcms_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wcms_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_joystick        (in_joystick),
    .in_rain            (in_rain),
    .in_motion          (in_motion),
    .in_window_distance (in_window_distance),
    .in_cover_distance  (in_cover_distance),
    .in_tilt_x          (in_tilt_x),
    .in_tilt_y          (in_tilt_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cover_run      (out_cover_run),
    .out_cover_opening  (out_cover_opening),
    .out_window_run     (out_window_run),
    .out_window_closing (out_window_closing),
    .out_buzzer         (out_buzzer),
    .out_window_goal    (out_window_goal),
    .out_cover_goal     (out_cover_goal),
    .out_window_settled (out_window_settled),
    .out_cover_settled  (out_cover_settled)
  );

endmodule
`default_nettype wire

>>> hw/rtl/wcms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wcms_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/wcms_ctl.sv
// Controller state machine stepping one sensor word through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module wcms_ctl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           out_ready,
  input  wire wcms_pkg::sts_t sts,
  output wcms_pkg::cmd_t      cmd
);
  import wcms_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // result register free, or its word leaves this cycle
        if (!sts.out_full || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wcms_datapath.sv
// Datapath: config registers, targets and done flags, distance history sums, motor step.
`timescale 1ns / 1ps
`default_nettype none
module wcms_datapath #(
  parameter int HISTORY_DEPTH = wcms_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wcms_pkg::cmd_t                  cmd,
  output wcms_pkg::sts_t                       sts,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wcms_pkg::CFG_DATA_W-1:0] cfg_data,
  // input word
  input  wire logic [11:0]                     in_joystick,
  input  wire logic [11:0]                     in_rain,
  input  wire logic                            in_motion,
  input  wire logic [9:0]                      in_window_distance,
  input  wire logic [9:0]                      in_cover_distance,
  input  wire logic signed [15:0]              in_tilt_x,
  input  wire logic signed [15:0]              in_tilt_y,
  // result word
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_cover_run,
  output logic                                 out_cover_opening,
  output logic                                 out_window_run,
  output logic                                 out_window_closing,
  output logic                                 out_buzzer,
  output logic                                 out_window_goal,
  output logic                                 out_cover_goal,
  output logic                                 out_window_settled,
  output logic                                 out_cover_settled
);
  import wcms_pkg::*;

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = 7 + CNT_W;
  localparam int SQ_W  = 13 + CNT_W;
  localparam int P1_W  = CNT_W + SQ_W;
  localparam int P2_W  = 2 * SUM_W;
  localparam int P3_W  = 2 * CNT_W;
  localparam int CMP_W = 16 + P3_W;

  // motor actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_C_CLS  = 3'd1;
  localparam logic [2:0] ACT_C_OPN  = 3'd2;
  localparam logic [2:0] ACT_W_CLS  = 3'd3;
  localparam logic [2:0] ACT_W_OPN  = 3'd4;

  localparam logic signed [11:0] LIM80 = 12'sd80;

  // ---------------- configuration registers ----------------
  logic        smart_off_r;
  logic [6:0]  open_pct_r;
  logic [6:0]  close_dist_r;
  logic [7:0]  open_dist_r;
  logic [7:0]  open_marg_r;
  logic [11:0] rain_lvl_r;
  logic [15:0] var_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smart_off_r  <= RST_SMART_OFF;
      open_pct_r   <= RST_OPEN_PCT;
      close_dist_r <= RST_CLOSE_DIST;
      open_dist_r  <= RST_OPEN_DIST;
      open_marg_r  <= RST_OPEN_MARG;
      rain_lvl_r   <= RST_RAIN_LVL;
      var_limit_r  <= RST_VAR_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SMART_OFF:  smart_off_r  <= cfg_data[0];
        REG_OPEN_PCT:   open_pct_r   <= cfg_data[6:0];
        REG_CLOSE_DIST: close_dist_r <= cfg_data[6:0];
        REG_OPEN_DIST:  open_dist_r  <= cfg_data[7:0];
        REG_OPEN_MARG:  open_marg_r  <= cfg_data[7:0];
        REG_RAIN_LVL:   rain_lvl_r   <= cfg_data[11:0];
        REG_VAR_LIMIT:  var_limit_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- captured input word ----------------
  logic [11:0]        joy_r, rain_r;
  logic               motion_r;
  logic [9:0]         wd_r, cd_r;
  logic signed [15:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      joy_r    <= in_joystick;
      rain_r   <= in_rain;
      motion_r <= in_motion;
      wd_r     <= in_window_distance;
      cd_r     <= in_cover_distance;
      tx_r     <= in_tilt_x;
      ty_r     <= in_tilt_y;
    end
  end

  // ---------------- history store ----------------
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]  sumsq_r, sumsq_nxt;
  logic [6:0]       old_smp;
  logic             append, full;

  assign append = !smart_off_r && (wd_r < DIST_VALID_BELOW);
  assign full   = (count_r == CNT_W'(HISTORY_DEPTH));

  wcms_ram #(
    .W (7),
    .D (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.upd && append),
    .waddr (head_r),
    .wdata (wd_r[6:0]),
    .raddr (head_r),
    .rdata (old_smp)
  );

  // running sum and sum of squares; the overwritten sample leaves when full
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    if (append) begin
      head_nxt  = (head_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
      sum_nxt   = sum_r + SUM_W'(wd_r[6:0]);
      sumsq_nxt = sumsq_r + SQ_W'(14'(wd_r[6:0]) * 14'(wd_r[6:0]));
      if (full) begin
        sum_nxt   = sum_nxt - SUM_W'(old_smp);
        sumsq_nxt = sumsq_nxt - SQ_W'(14'(old_smp) * 14'(old_smp));
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // ---------------- target rules ----------------
  logic win_tgt_r, cov_tgt_r, win_done_r, cov_done_r, motion_prev_r, edge_r;
  logic wt, ct, wdn, cdn, tilt;

  assign tilt = (tx_r >= TILT_POS) || (tx_r <= TILT_NEG) ||
                (ty_r >= TILT_POS) || (ty_r <= TILT_NEG);

  always_comb begin
    wt  = win_tgt_r;
    ct  = cov_tgt_r;
    wdn = win_done_r;
    cdn = cov_done_r;
    // joystick
    if (joy_r < JOY_OPEN_BELOW) begin
      if (ct) begin
        ct  = 1'b0;
        cdn = 1'b0;
      end
      if (wt) begin
        wt  = 1'b0;
        wdn = 1'b0;
      end
    end else if (joy_r >= JOY_CLOSE_FROM) begin
      if (!ct) begin
        ct  = 1'b1;
        cdn = 1'b0;
      end
      if (!wt) begin
        wt  = 1'b1;
        wdn = 1'b0;
      end
    end
    // smart mode: rain and tilt
    if (!smart_off_r) begin
      if (rain_r < rain_lvl_r) begin
        wt  = 1'b1;
        wdn = 1'b0;
      end
      if (tilt && (wd_r != '0)) begin
        wt  = 1'b1;
        ct  = 1'b1;
        wdn = 1'b0;
      end
    end
  end

  // ---------------- variance and opening target arithmetic ----------------
  logic [P1_W-1:0]  p1_r;
  logic [P2_W-1:0]  p2_r;
  logic [P3_W-1:0]  p3_r;
  logic [CMP_W-1:0] p4_r, diff_r;
  logic [14:0]      prod_r;
  logic [8:0]       q_r, th_r;
  logic [15:0]      rem;
  logic             over_r;

  assign rem = 16'(prod_r) - 16'(q_r) * 16'd100;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1_r   <= P1_W'(count_r) * P1_W'(sumsq_r);
      p2_r   <= P2_W'(sum_r) * P2_W'(sum_r);
      p3_r   <= P3_W'(count_r) * P3_W'(count_r - 1'b1);
      prod_r <= 15'(open_pct_r) * 15'(open_dist_r);
    end
    if (cmd.mul2) begin
      p4_r   <= CMP_W'(var_limit_r) * CMP_W'(p3_r);
      diff_r <= CMP_W'(p1_r) - CMP_W'(p2_r);
      q_r    <= 9'((26'(prod_r) * 26'(RECIP_100)) >> RECIP_SHIFT);
    end
    if (cmd.fix) begin
      th_r   <= (rem >= 16'd100) ? q_r + 1'b1 : q_r;
      over_r <= (diff_r > p4_r);
    end
  end

  // ---------------- motor step ----------------
  logic               crun, copen, wrun, wclose, wdn_m, cdn_m, buzz;
  logic [2:0]         act;
  logic signed [11:0] wds, cds, cls, ods, th_lo, th_hi;

  assign wds   = $signed({2'b00, wd_r});
  assign cds   = $signed({2'b00, cd_r});
  assign cls   = $signed({5'b00000, close_dist_r});
  assign ods   = $signed({4'b0000, open_dist_r});
  assign th_lo = $signed({3'b000, th_r}) - $signed({4'b0000, open_marg_r});
  assign th_hi = $signed({3'b000, th_r}) + $signed({4'b0000, open_marg_r});
  assign buzz  = edge_r && (count_r >= CNT_W'(2)) && over_r;

  always_comb begin
    crun   = 1'b0;
    copen  = 1'b0;
    wrun   = 1'b0;
    wclose = 1'b0;
    wdn_m  = win_done_r;
    cdn_m  = cov_done_r;
    // pick the step of the cover/window sequence
    if (cov_tgt_r && win_tgt_r) begin
      act = win_done_r ? ACT_C_CLS : ACT_W_CLS;
    end else if (!cov_tgt_r && win_tgt_r) begin
      act = cov_done_r ? ACT_W_CLS : ACT_C_OPN;
    end else if (!cov_tgt_r && !win_tgt_r) begin
      act = cov_done_r ? ACT_W_OPN : ACT_C_OPN;
    end else begin
      act = ACT_NONE;
    end
    case (act)
      ACT_C_CLS: begin
        if (!cov_done_r && cds > cls && cds < LIM80) crun = 1'b1;
        else cdn_m = 1'b1;
      end
      ACT_C_OPN: begin
        if (!cov_done_r && (cds < ods || cds > LIM80)) begin
          crun  = 1'b1;
          copen = 1'b1;
        end else cdn_m = 1'b1;
      end
      ACT_W_CLS: begin
        if (!win_done_r && wds > cls && wds < LIM80) begin
          wrun   = 1'b1;
          wclose = 1'b1;
        end else wdn_m = 1'b1;
      end
      ACT_W_OPN: begin
        if (!win_done_r && (wds < th_lo || wds > LIM80)) begin
          wrun = 1'b1;
        end else if (!win_done_r && wds > th_hi) begin
          wrun   = 1'b1;
          wclose = 1'b1;
        end else wdn_m = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- block state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_tgt_r     <= 1'b0;
      cov_tgt_r     <= 1'b0;
      win_done_r    <= 1'b0;
      cov_done_r    <= 1'b0;
      motion_prev_r <= 1'b0;
      edge_r        <= 1'b0;
      head_r        <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      sumsq_r       <= '0;
    end else if (cmd.upd) begin
      win_tgt_r  <= wt;
      cov_tgt_r  <= ct;
      win_done_r <= wdn;
      cov_done_r <= cdn;
      edge_r     <= !smart_off_r && !motion_prev_r && motion_r;
      if (!smart_off_r) motion_prev_r <= motion_r;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      sumsq_r    <= sumsq_nxt;
    end else if (cmd.fin) begin
      win_done_r <= wdn_m;
      cov_done_r <= cdn_m;
    end
  end

  // ---------------- result register ----------------
  logic out_valid_r;
  logic o_crun_r, o_copen_r, o_wrun_r, o_wclose_r, o_buzz_r;
  logic o_wgoal_r, o_cgoal_r, o_wset_r, o_cset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      o_crun_r   <= crun;
      o_copen_r  <= copen;
      o_wrun_r   <= wrun;
      o_wclose_r <= wclose;
      o_buzz_r   <= buzz;
      o_wgoal_r  <= win_tgt_r;
      o_cgoal_r  <= cov_tgt_r;
      o_wset_r   <= wdn_m;
      o_cset_r   <= cdn_m;
    end
  end

  assign sts.out_full       = out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_cover_run      = o_crun_r;
  assign out_cover_opening  = o_copen_r;
  assign out_window_run     = o_wrun_r;
  assign out_window_closing = o_wclose_r;
  assign out_buzzer         = o_buzz_r;
  assign out_window_goal    = o_wgoal_r;
  assign out_cover_goal     = o_cgoal_r;
  assign out_window_settled = o_wset_r;
  assign out_cover_settled  = o_cset_r;

endmodule
`default_nettype wire
